// ----- design/bct_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and index helper for the binomial coefficient table.
package bct_pkg;

    localparam int IDX_W     = 12;
    localparam int NUM_W     = 7;
    localparam int DATA_W    = 64;
    localparam int SEED_CNT  = 4;
    localparam int FIRST_ROW = 7;

    localparam int DEF_MAX_N       = 67;
    localparam int DEF_TABLE_DEPTH = 1056;

    localparam logic [DATA_W-1:0] ALL_ONES = '1;

    // C(4,2), C(5,2), C(6,2), C(6,3)
    localparam logic [DATA_W-1:0] SEED_VAL [SEED_CNT] = '{64'd6, 64'd10, 64'd15, 64'd20};

    typedef enum logic [1:0] {
        BLD_SEED,
        BLD_ROWS,
        BLD_DRAIN,
        BLD_DONE
    } bld_state_t;

    typedef enum logic [2:0] {
        RK_ZERO,
        RK_ONE,
        RK_SMALL,
        RK_TABLE,
        RK_ALL1
    } rslt_kind_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
    } tbl_rd_t;

    // Row-major position of C(nn,kf), 2 <= kf <= nn/2, rows starting at nn = 4
    function automatic logic [IDX_W-1:0] tbl_idx(input logic [NUM_W-1:0] nn,
                                                 input logic [NUM_W-1:0] kf);
        logic [5:0]       h1;
        logic [5:0]       h2;
        logic [NUM_W-1:0] nm1;
        logic [IDX_W-1:0] prod;
        h1   = nn[6:1];
        nm1  = nn - 7'd1;
        h2   = nm1[6:1];
        prod = IDX_W'(h1) * IDX_W'(h2);
        return prod - IDX_W'(nn) + IDX_W'(kf);
    endfunction

endpackage

// ----- design/binomial_coefficient_table_core.sv -----
`timescale 1ns / 1ps
// Top level: query decode, table read pipeline and result register.
//
// Usage notes
//   Query channel (query_valid/query_ready, opcode, n, k) carries one beat per
//   coefficient request; the result channel (result_valid/result_ready, value,
//   error) returns exactly one beat per query, in order.
//   After reset the block builds its coefficient table: four seed writes, one
//   write per stored entry of rows 7..MAX_N (1052 at the default size) and a
//   final drain state. query_ready stays low meanwhile.
//   The table read of a query is launched at the accepting edge; the result
//   register loads from the read stage when it is empty or its beat is taken.
//   Throughput: one query per cycle once the table is built and the receiver
//   does not stall, limited by the single read port of the table memory.
//   When the receiver stalls, the result register holds its beat and one more
//   query may sit in the read stage; further queries see query_ready low until
//   the result beat is taken.
module binomial_coefficient_table_core
    import bct_pkg::*;
#(
    parameter int MAX_N       = DEF_MAX_N,
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              query_valid,
    output logic              query_ready,
    input  logic              opcode,
    input  logic signed [7:0] n,
    input  logic signed [7:0] k,
    output logic              result_valid,
    input  logic              result_ready,
    output logic [63:0]       value,
    output logic              error
);

    tbl_rd_t           rd_req;
    logic [DATA_W-1:0] tbl_data;
    logic              tbl_busy;

    logic              query_acc, out_adv;

    rslt_kind_t        dec_kind;
    logic              dec_neg, dec_err;
    logic [7:0]        un, nu;
    logic [NUM_W-1:0]  kk, un7, kf;
    logic [IDX_W-1:0]  dec_idx;

    logic              s1_valid_reg;
    rslt_kind_t        s1_kind_reg;
    logic [NUM_W-1:0]  s1_small_reg;
    logic              s1_neg_reg, s1_err_reg;

    logic              out_valid_reg;
    logic [DATA_W-1:0] value_reg, value_next;
    logic              error_reg;
    logic [DATA_W-1:0] base;

    bct_table #(
        .MAX_N       (MAX_N),
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_req  (rd_req),
        .rd_data (tbl_data),
        .busy    (tbl_busy)
    );

    assign out_adv     = !out_valid_reg || result_ready;
    assign query_ready = !tbl_busy && (!s1_valid_reg || out_adv);
    assign query_acc   = query_valid && query_ready;

    // Negative n in signed mode maps to C(k-n-1, k)
    always_comb
    begin
        kk  = k[6:0];
        nu  = 8'(k) - 8'(n) - 8'd1;
        un  = (opcode && n[7]) ? nu : 8'(n);
        un7 = un[6:0];
        kf  = ({1'b0, kk} > (un >> 1)) ? (un7 - kk) : kk;
        dec_idx = tbl_idx(un7, kf);

        dec_kind = RK_ZERO;
        dec_neg  = 1'b0;
        dec_err  = 1'b0;
        priority if (k[7])
        begin
            dec_kind = RK_ZERO;
        end
        else if (!opcode && n[7])
        begin
            dec_kind = RK_ZERO;
        end
        else if (opcode && !n[7] && (n[6:0] > NUM_W'(MAX_N - 1)))
        begin
            dec_kind = RK_ALL1;
            dec_err  = 1'b1;
        end
        else
        begin
            dec_neg = opcode && n[7] && k[0];
            priority if (un > 8'(MAX_N) || {1'b0, kk} > un)
            begin
                dec_kind = RK_ZERO;
            end
            else if (kk == '0 || {1'b0, kk} == un)
            begin
                dec_kind = RK_ONE;
            end
            else if (kk == NUM_W'(1) || {1'b0, kk} == un - 8'd1)
            begin
                dec_kind = RK_SMALL;
            end
            else if (dec_idx < IDX_W'(TABLE_DEPTH))
            begin
                dec_kind = RK_TABLE;
            end
            else
            begin
                dec_kind = RK_ZERO;
            end
        end
    end

    assign rd_req.en  = query_acc && (dec_kind == RK_TABLE);
    assign rd_req.idx = dec_idx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (query_acc)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (out_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (query_acc)
        begin
            s1_kind_reg  <= dec_kind;
            s1_small_reg <= un7;
            s1_neg_reg   <= dec_neg;
            s1_err_reg   <= dec_err;
        end
    end

    always_comb
    begin
        unique case (s1_kind_reg)
            RK_ZERO:  base = '0;
            RK_ONE:   base = DATA_W'(1);
            RK_SMALL: base = DATA_W'(s1_small_reg);
            RK_TABLE: base = tbl_data;
            RK_ALL1:  base = ALL_ONES;
            default:  base = '0;
        endcase
        value_next = s1_neg_reg ? (~base + DATA_W'(1)) : base;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_adv)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_adv && s1_valid_reg)
        begin
            value_reg <= value_next;
            error_reg <= s1_err_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign value        = value_reg;
    assign error        = error_reg;

    a_err_all_ones: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && error |-> value == ALL_ONES)
        else $error("error beat without all-ones value");

    a_read_data_held: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && result_valid && !result_ready |-> !query_ready)
        else $error("new read issued while read stage is stalled");

    a_no_query_in_build: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_busy |-> !query_ready)
        else $error("query taken during table build");

    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        query_valid && query_ready |=> s1_valid_reg)
        else $error("accepted beat lost before read stage");

endmodule

// ----- design/bct_table.sv -----
`timescale 1ns / 1ps
// Coefficient memory with its post-reset Pascal-rule build sequencer.
module bct_table
    import bct_pkg::*;
#(
    parameter int MAX_N       = DEF_MAX_N,
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  tbl_rd_t           rd_req,
    output logic [DATA_W-1:0] rd_data,
    output logic              busy
);

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [DATA_W-1:0] mem [TABLE_DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    bld_state_t        state_reg, state_next;
    logic [1:0]        seed_reg, seed_next;
    logic [NUM_W-1:0]  row_reg, row_next;
    logic [5:0]        col_reg, col_next;
    logic [IDX_W-1:0]  widx_reg, widx_next;
    logic [DATA_W-1:0] prev_reg, prev_next;
    logic              b_valid_reg, b_first_reg, b_ok_reg;
    logic [NUM_W-1:0]  b_row_reg;
    logic [IDX_W-1:0]  b_widx_reg;

    logic              issue, seed_we;
    logic              row_end, last_entry;
    logic [NUM_W-1:0]  up_n, up_k, col7;
    logic [IDX_W-1:0]  up_idx;
    logic              up_ok;
    logic [DATA_W-1:0] up_data, sum;

    logic              we, re;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [DATA_W-1:0] wdata;

    // Entry above: C(row-1, col), folded into the stored half of the row
    always_comb
    begin
        col7   = NUM_W'(col_reg);
        up_n   = row_reg - 7'd1;
        up_k   = (col7 > {1'b0, up_n[6:1]}) ? (up_n - col7) : col7;
        up_idx = tbl_idx(up_n, up_k);
        up_ok  = up_idx < IDX_W'(TABLE_DEPTH);
    end

    assign row_end    = (col_reg == row_reg[6:1]);
    assign last_entry = row_end && (row_reg == NUM_W'(MAX_N));

    always_comb
    begin
        state_next = state_reg;
        issue      = 1'b0;
        seed_we    = 1'b0;
        unique case (state_reg)
            BLD_SEED:
            begin
                seed_we = 1'b1;
                if (seed_reg == 2'(SEED_CNT - 1))
                begin
                    state_next = (MAX_N >= FIRST_ROW) ? BLD_ROWS : BLD_DONE;
                end
            end
            BLD_ROWS:
            begin
                issue = 1'b1;
                if (last_entry)
                begin
                    state_next = BLD_DRAIN;
                end
            end
            BLD_DRAIN:
            begin
                state_next = BLD_DONE;
            end
            BLD_DONE:
            begin
                state_next = BLD_DONE;
            end
        endcase
    end

    assign up_data = b_ok_reg ? rd_data_reg : '0;
    // first column of a row: C(row-1,1) = row-1
    assign sum     = (b_first_reg ? DATA_W'(b_row_reg - 7'd1) : prev_reg) + up_data;

    always_comb
    begin
        seed_next = seed_we ? seed_reg + 2'd1 : seed_reg;
        row_next  = row_reg;
        col_next  = col_reg;
        widx_next = widx_reg;
        if (issue)
        begin
            widx_next = widx_reg + IDX_W'(1);
            if (row_end)
            begin
                row_next = row_reg + 7'd1;
                col_next = 6'd2;
            end
            else
            begin
                col_next = col_reg + 6'd1;
            end
        end
        prev_next = b_valid_reg ? up_data : prev_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= BLD_SEED;
            seed_reg    <= '0;
            row_reg     <= NUM_W'(FIRST_ROW);
            col_reg     <= 6'd2;
            widx_reg    <= IDX_W'(SEED_CNT);
            prev_reg    <= '0;
            b_valid_reg <= 1'b0;
            b_first_reg <= 1'b0;
            b_ok_reg    <= 1'b0;
            b_row_reg   <= '0;
            b_widx_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            seed_reg    <= seed_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            widx_reg    <= widx_next;
            prev_reg    <= prev_next;
            b_valid_reg <= issue;
            b_first_reg <= issue && (col_reg == 6'd2);
            b_ok_reg    <= up_ok;
            b_row_reg   <= row_reg;
            b_widx_reg  <= widx_reg;
        end
    end

    // Single write port: seeds first, then one Pascal-rule entry per cycle
    always_comb
    begin
        we    = 1'b0;
        waddr = '0;
        wdata = sum;
        if (seed_we)
        begin
            we    = IDX_W'(seed_reg) < IDX_W'(TABLE_DEPTH);
            waddr = ADDR_W'(seed_reg);
            wdata = SEED_VAL[seed_reg];
        end
        else if (b_valid_reg)
        begin
            we    = b_widx_reg < IDX_W'(TABLE_DEPTH);
            waddr = b_widx_reg[ADDR_W-1:0];
        end
    end

    assign re    = issue || rd_req.en;
    assign raddr = issue ? up_idx[ADDR_W-1:0] : rd_req.idx[ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = (state_reg != BLD_DONE);

    a_rows_only_in_build: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |-> (state_reg == BLD_ROWS || state_reg == BLD_DRAIN))
        else $error("build write stage active outside the row build");

    a_done_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BLD_DONE |=> state_reg == BLD_DONE)
        else $error("table build restarted after completion");

    a_finish_drained: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> !b_valid_reg && !issue)
        else $error("build finished with a write still pending");

endmodule
